>>> hdl/mmfw_pkg.sv
// Shared constants, types and command/status structs for the water-filling unit.
`default_nettype none
package mmfw_pkg;
  localparam int MAX_DEMANDS = 64;
  localparam int RATE_BITS   = 48;
  localparam int CNT_W       = $clog2(MAX_DEMANDS + 1);
  localparam int IDX_W       = (MAX_DEMANDS > 1) ? $clog2(MAX_DEMANDS) : 1;

  typedef logic [RATE_BITS-1:0] rate_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    logic load;
    logic ins_rd;
    logic ins_shift;
    logic ins_put;
    logic fill_init;
    logic fill_rd;
    logic fill_adv;
    logic fill_fin;
    logic emit_init;
    logic emit_rd;
    logic emit_out;
  } cmd_t;

  typedef struct packed {
    logic store_ok;
    logic last;
    logic idx_zero;
    logic ins_gt;
    logic at_end;
    logic div_busy;
    logic fits;
    logic emit_last;
  } sts_t;
endpackage
`default_nettype wire

>>> hdl/max_min_fair_waterlevel_unit.sv
// Top level of the max-min fair water-filling unit.
//
// Usage: a set of demands is fed one request per start pulse; a request is
// taken at a rising edge with start high and busy low. link_capacity_i is
// latched from the first request of a set; last_demand_i ends the set.
// Up to MAX_DEMANDS (64) requests are stored per set; later ones are dropped
// but a last flag on them still closes the set.
// Per request: a load step, then a read and a shift for each sorted entry
// moved by the insertion sort on the single-port sorted store, and last the
// placing of the new entry.
// After the last request the fill walk costs, per sorted entry visited,
// one read, a run of the bit-serial divider and one update.
// Results then stream in arrival order (arrival store read, then present),
// each shown for exactly one cycle with result_valid_o high; last_result_o
// marks the final one. The receiver cannot stall, so no backpressure
// exists. busy is high while a request is inserted and, after a last
// request, until the set's last result is shown.
// Reset (rst_ni low, async) clears the demand count, capacity and state;
// the stores are not cleared, entries are only read after being written.
`default_nettype none
module max_min_fair_waterlevel_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire mmfw_pkg::rate_t link_capacity_i,
  input  wire mmfw_pkg::rate_t demand_i,
  input  wire logic            last_demand_i,
  output logic                 result_valid_o,
  output mmfw_pkg::rate_t      allocation_o,
  output mmfw_pkg::rate_t      water_level_o,
  output logic                 last_result_o
);
  import mmfw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mmfw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .strobe_o (result_valid_o)
  );

  mmfw_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .link_capacity_i (link_capacity_i),
    .demand_i        (demand_i),
    .last_demand_i   (last_demand_i),
    .allocation_o    (allocation_o),
    .water_level_o   (water_level_o)
  );

  assign last_result_o = sts.emit_last;
endmodule
`default_nettype wire

>>> hdl/mmfw_div.sv
// Restoring divider: rate-wide dividend by count-wide divisor, one bit per cycle.
`default_nettype none
module mmfw_div (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire mmfw_pkg::rate_t dividend_i,
  input  wire mmfw_pkg::cnt_t  divisor_i,
  output logic                 busy_o,
  output mmfw_pkg::rate_t      quotient_o
);
  import mmfw_pkg::*;

  localparam int STEP_W = $clog2(RATE_BITS + 1);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  rate_t             quo_q, quo_d;
  cnt_t              rem_q, rem_d;
  cnt_t              dvs_q, dvs_d;
  logic [CNT_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, quo_q[RATE_BITS-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(RATE_BITS);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
      quo_d  = {quo_q[RATE_BITS-2:0], ge};
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

>>> hdl/mmfw_datapath.sv
// Datapath: demand stores, insertion sort, level fill arithmetic and result drive.
`default_nettype none
module mmfw_datapath (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mmfw_pkg::cmd_t  cmd_i,
  output mmfw_pkg::sts_t       sts_o,
  input  wire mmfw_pkg::rate_t link_capacity_i,
  input  wire mmfw_pkg::rate_t demand_i,
  input  wire logic            last_demand_i,
  output mmfw_pkg::rate_t      allocation_o,
  output mmfw_pkg::rate_t      water_level_o
);
  import mmfw_pkg::*;

  rate_t arrival_mem [MAX_DEMANDS];
  rate_t sorted_mem  [MAX_DEMANDS];

  cnt_t  count_q, idx_q;
  rate_t cap_q, d_q, level_q, rem_q, srd_q, ard_q;
  logic  last_q;

  rate_t                    delta, quo;
  cnt_t                     left, idx_m1;
  logic [RATE_BITS+CNT_W-1:0] prod;
  logic                     div_busy;

  assign delta  = srd_q - level_q;
  assign left   = count_q - idx_q;
  assign idx_m1 = idx_q - 1'b1;
  assign prod   = delta * left;

  mmfw_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.fill_rd),
    .dividend_i (rem_q),
    .divisor_i  (left),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  // stores and their registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < cnt_t'(MAX_DEMANDS)))
      arrival_mem[count_q[IDX_W-1:0]] <= demand_i;
    if (cmd_i.emit_rd) ard_q <= arrival_mem[idx_q[IDX_W-1:0]];
    if (cmd_i.ins_shift) sorted_mem[idx_q[IDX_W-1:0]] <= srd_q;
    else if (cmd_i.ins_put) sorted_mem[idx_q[IDX_W-1:0]] <= d_q;
    if (cmd_i.ins_rd) srd_q <= sorted_mem[idx_m1[IDX_W-1:0]];
    else if (cmd_i.fill_rd) srd_q <= sorted_mem[idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      d_q    <= demand_i;
      last_q <= last_demand_i;
    end
    if (cmd_i.fill_init) rem_q <= cap_q;
    else if (cmd_i.fill_adv) rem_q <= rem_q - prod[RATE_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= '0;
      idx_q   <= '0;
      level_q <= '0;
    end else begin
      if (cmd_i.load) begin
        if (count_q == '0) cap_q <= link_capacity_i;
        idx_q <= count_q;
      end
      if (cmd_i.ins_shift) idx_q <= idx_m1;
      if (cmd_i.ins_put) count_q <= count_q + 1'b1;
      if (cmd_i.fill_init) begin
        level_q <= '0;
        idx_q   <= '0;
      end
      if (cmd_i.fill_adv) begin
        level_q <= level_q + delta;
        idx_q   <= idx_q + 1'b1;
      end
      if (cmd_i.fill_fin) level_q <= level_q + quo;
      if (cmd_i.emit_init) idx_q <= '0;
      if (cmd_i.emit_out) begin
        if (sts_o.emit_last) count_q <= '0;
        else idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign sts_o.store_ok  = count_q < cnt_t'(MAX_DEMANDS);
  assign sts_o.last      = last_q;
  assign sts_o.idx_zero  = idx_q == '0;
  assign sts_o.ins_gt    = srd_q > d_q;
  assign sts_o.at_end    = idx_q == count_q;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.fits      = delta <= quo;
  assign sts_o.emit_last = idx_q == (count_q - 1'b1);

  assign allocation_o  = (ard_q < level_q) ? ard_q : level_q;
  assign water_level_o = level_q;
endmodule
`default_nettype wire

>>> hdl/mmfw_ctrl.sv
// Controller: sequences load, insertion, water fill and result streaming.
`default_nettype none
module mmfw_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire mmfw_pkg::sts_t sts_i,
  output mmfw_pkg::cmd_t      cmd_o,
  output logic                busy_o,
  output logic                strobe_o
);
  import mmfw_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_CHK = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_F_INIT  = 4'd3;
  localparam logic [3:0] S_F_RD    = 4'd4;
  localparam logic [3:0] S_F_DIV   = 4'd5;
  localparam logic [3:0] S_F_UPD   = 4'd6;
  localparam logic [3:0] S_E_INIT  = 4'd7;
  localparam logic [3:0] S_E_RD    = 4'd8;
  localparam logic [3:0] S_E_OUT   = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        // a full set still takes the load step so a last flag is seen
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (!sts_i.store_ok) begin
          // dropped request on a full set; only a last flag matters
          state_d = sts_i.last ? S_F_INIT : S_IDLE;
        end else if (sts_i.idx_zero) begin
          cmd_o.ins_put = 1'b1;
          state_d = sts_i.last ? S_F_INIT : S_IDLE;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts_i.ins_gt) begin
          cmd_o.ins_shift = 1'b1;
          state_d = S_INS_CHK;
        end else begin
          cmd_o.ins_put = 1'b1;
          state_d = sts_i.last ? S_F_INIT : S_IDLE;
        end
      end
      S_F_INIT: begin
        cmd_o.fill_init = 1'b1;
        state_d = S_F_RD;
      end
      S_F_RD: begin
        if (sts_i.at_end) state_d = S_E_INIT;
        else begin
          cmd_o.fill_rd = 1'b1;
          state_d = S_F_DIV;
        end
      end
      S_F_DIV: begin
        if (!sts_i.div_busy) state_d = S_F_UPD;
      end
      S_F_UPD: begin
        if (sts_i.fits) begin
          cmd_o.fill_adv = 1'b1;
          state_d = S_F_RD;
        end else begin
          cmd_o.fill_fin = 1'b1;
          state_d = S_E_INIT;
        end
      end
      S_E_INIT: begin
        cmd_o.emit_init = 1'b1;
        state_d = S_E_RD;
      end
      S_E_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d = S_E_OUT;
      end
      S_E_OUT: begin
        cmd_o.emit_out = 1'b1;
        state_d = sts_i.emit_last ? S_IDLE : S_E_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign busy_o   = state_q != S_IDLE;
  assign strobe_o = cmd_o.emit_out;
endmodule
`default_nettype wire

>>> hdl/mmfw_checker.sv
// Port-level checker for the water-filling unit, bound to the top level.
`default_nettype none
module mmfw_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            busy,
  input wire logic            result_valid_o,
  input wire mmfw_pkg::rate_t allocation_o,
  input wire mmfw_pkg::rate_t water_level_o,
  input wire logic            last_result_o
);
  a_res_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result outside busy window");
  a_res_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("back-to-back results");
  a_alloc_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> allocation_o <= water_level_o)
    else $error("allocation above level");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_result_o |=> !busy) else $error("busy after last result");
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |=> busy) else $error("set ended early");
endmodule

bind max_min_fair_waterlevel_unit mmfw_checker u_mmfw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .allocation_o   (allocation_o),
  .water_level_o  (water_level_o),
  .last_result_o  (last_result_o)
);
`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the max-min fair water-filling unit.
`timescale 1ns / 1ps
module testbench;
  import mmfw_pkg::*;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  rate_t link_capacity_i = '0;
  rate_t demand_i = '0;
  logic  last_demand_i = 1'b0;
  logic  result_valid_o;
  rate_t allocation_o;
  rate_t water_level_o;
  logic  last_result_o;

  max_min_fair_waterlevel_unit dut (
    .clk_i, .rst_ni, .start, .busy, .link_capacity_i, .demand_i, .last_demand_i,
    .result_valid_o, .allocation_o, .water_level_o, .last_result_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  typedef struct {
    rate_t alloc;
    rate_t level;
    logic  fin;
  } grant_t;

  // Predictor state: its own copy of both stores.
  rate_t  flow_arrival[MAX_DEMANDS];
  rate_t  flow_sorted[MAX_DEMANDS];
  int     flow_cnt = 0;
  rate_t  share_cap = '0;
  grant_t grants_due[$];

  int errors = 0;
  int requests_sent = 0;
  int grants_seen = 0;
  int sets_closed = 0;
  int send_idle_pct = 35;

  // Water-fill over the sorted demands of the current set.
  function automatic rate_t fair_level(rate_t cap, int n);
    logic [63:0] lvl;
    logic [63:0] left;
    logic [63:0] delta;
    logic [63:0] c;
    int nx;
    lvl = '0;
    c = 64'(cap);
    nx = 0;
    while (nx < n) begin
      delta = 64'(flow_sorted[nx]) - lvl;
      left = 64'(n - nx);
      if (delta <= c / left) begin
        lvl += delta;
        c -= delta * left;
        nx++;
      end else begin
        lvl += c / left;
        break;
      end
    end
    return lvl[RATE_BITS-1:0];
  endfunction

  // Apply one accepted request to the predictor.
  task automatic predict_grants(rate_t cap, rate_t d, logic lst);
    int i;
    rate_t lvl;
    grant_t g;
    if (flow_cnt == 0) share_cap = cap;
    if (flow_cnt < MAX_DEMANDS) begin
      flow_arrival[flow_cnt] = d;
      i = flow_cnt;
      while (i > 0 && flow_sorted[i-1] > d) begin
        flow_sorted[i] = flow_sorted[i-1];
        i--;
      end
      flow_sorted[i] = d;
      flow_cnt++;
    end
    if (lst) begin
      lvl = fair_level(share_cap, flow_cnt);
      for (int k = 0; k < flow_cnt; k++) begin
        g.alloc = (flow_arrival[k] < lvl) ? flow_arrival[k] : lvl;
        g.level = lvl;
        g.fin = (k + 1 == flow_cnt);
        grants_due.push_back(g);
      end
      flow_cnt = 0;
      sets_closed++;
    end
  endtask

  // Result checker: strobe cannot be held off.
  always @(posedge clk_i) begin
    grant_t g;
    if (rst_ni && result_valid_o) begin
      grants_seen++;
      if (grants_due.size() == 0) begin
        $display("%0t: unexpected result alloc=%h level=%h", $time, allocation_o,
                 water_level_o);
        errors++;
      end else begin
        g = grants_due.pop_front();
        if (allocation_o !== g.alloc) begin
          $display("%0t: allocation exp %h got %h", $time, g.alloc, allocation_o);
          errors++;
        end
        if (water_level_o !== g.level) begin
          $display("%0t: water_level exp %h got %h", $time, g.level, water_level_o);
          errors++;
        end
        if (last_result_o !== g.fin) begin
          $display("%0t: last_result exp %b got %b", $time, g.fin, last_result_o);
          errors++;
        end
      end
    end
  end

  // Issue one request and hold it until taken; start drops only on idle cycles.
  task automatic send_request(rate_t cap, rate_t d, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    link_capacity_i <= cap;
    demand_i <= d;
    last_demand_i <= lst;
    do @(posedge clk_i); while (busy);
    predict_grants(cap, d, lst);
    requests_sent++;
  endtask

  function automatic rate_t rnd_rate(int mode);
    rate_t r;
    r = rate_t'({$urandom, $urandom});
    case (mode)
      0: return r;
      1: return r & 48'hFFFF;
      2: return r & 48'hFF;
      default: return $urandom_range(3) ? r >> $urandom_range(47) : '0;
    endcase
  endfunction

  // Directed table: capacity, demand, last flag.
  typedef struct {
    rate_t cap;
    rate_t d;
    logic  lst;
  } row_t;

  localparam rate_t RMAX = {RATE_BITS{1'b1}};
  row_t plan[] = '{
    '{RMAX, RMAX, 1'b1},          // single full-scale demand, all satisfied
    '{'0,   RMAX, 1'b1},          // zero capacity
    '{RMAX, '0, 1'b1},            // zero demand
    '{100, 10, 1'b0}, '{0, 50, 1'b0}, '{0, 30, 1'b1},   // all demands met, capacity left over
    '{1000, 5, 1'b0}, '{0, 7, 1'b1},                    // capacity left over
    '{10, 4, 1'b0}, '{0, 4, 1'b0}, '{0, 4, 1'b1},       // ties
    '{RMAX, RMAX, 1'b0}, '{0, RMAX, 1'b0}, '{0, 48'h555555555555, 1'b1},
    '{48'hAAAAAAAAAAAA, 48'h000000000001, 1'b0}, '{0, 3, 1'b1}
  };
  // Single-request rows with an obvious answer.
  localparam rate_t PLAN_ALLOC[3] = '{RMAX, '0, '0};

  initial begin
    int n;
    int mode;
    rate_t cap;
    rate_t d;
    grant_t g;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < plan.size(); r++) begin
      send_request(plan[r].cap, plan[r].d, plan[r].lst);
      if (r < 3) begin
        g = grants_due[grants_due.size()-1];
        if (g.alloc !== PLAN_ALLOC[r]) begin
          $display("%0t: predictor row %0d exp %h got %h", $time, r, PLAN_ALLOC[r],
                   g.alloc);
          errors++;
        end
      end
    end

    // Overflow set: 66 requests, the last two dropped.
    for (int k = 0; k < MAX_DEMANDS + 2; k++)
      send_request(k == 0 ? rate_t'(48'h1000) : rnd_rate(0), rnd_rate(2),
                   k == MAX_DEMANDS + 1);

    // Random sets in three idle phases; mostly small sets.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 85 : 0;
      for (int s = 0; s < 5; s++) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(MAX_DEMANDS, 30)
                                     : $urandom_range(8, 1);
        mode = $urandom_range(3);
        cap = rnd_rate($urandom_range(3));
        for (int k = 0; k < n; k++) begin
          d = rnd_rate(mode);
          send_request(k == 0 ? cap : rnd_rate(0), d, k == n - 1);
        end
      end
    end
    start <= 1'b0;

    while (grants_due.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d requests in %0d sets, checked %0d allocations.",
             requests_sent, sets_closed, grants_seen);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end
endmodule
